FILE: hdl/tournament_argmax_score_table_core_defines.svh
// assertion helpers used by tast_ctrl
`ifndef TOURNAMENT_ARGMAX_SCORE_TABLE_CORE_DEFINES_SVH
`define TOURNAMENT_ARGMAX_SCORE_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TAST_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TAST_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/tast_pkg.sv
`default_nettype none

package tast_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 1024;
  localparam int unsigned SCORE_BITS_DEF  = 24;
  localparam int unsigned IDX_W           = 11;
  localparam int unsigned CFG_W           = 32;
  localparam int unsigned ADDR_W          = 3;

  localparam logic [ADDR_W-1:0] REG_ENTRIES_IN_USE = ADDR_W'(0);

  typedef enum logic [1:0] {
    KIND_REPORT,
    KIND_DELETE,
    KIND_ADD_ONE,
    KIND_ADD_THREE
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROOT,
    ST_REPORT,
    ST_DEL,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_UP_RD,
    ST_UP_WR,
    ST_SW_RD,
    ST_SW_WR
  } state_e;

  typedef struct packed {
    logic in_stall;
    logic accept;
    logic clr_wr;
    logic sw_init;
    logic rd_root;
    logic out_load;
    logic del_wr;
    logic leaf_rd;
    logic leaf_wr;
    logic node_wr;
    logic step_down;
  } cmd_t;

  typedef struct packed {
    logic  cfg_hit;
    logic  clr_last;
    kind_e in_kind;
    kind_e item_kind;
    logic  pos_ok;
    logic  root_live;
    logic  out_free;
    logic  p_is_root;
  } sts_t;

endpackage

`default_nettype wire

FILE: hdl/tast_ram.sv
`default_nettype none

module tast_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]        rdata_a_o,
  output logic [WIDTH-1:0]        rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

FILE: hdl/tast_ctrl.sv
`default_nettype none
`include "tournament_argmax_score_table_core_defines.svh"

module tast_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  tast_pkg::sts_t      sts_i,
  output tast_pkg::cmd_t      cmd_o
);
  import tast_pkg::*;

  state_e state_q, state_d;
  logic   pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.in_stall = 1'b1;
    pend_d  = pend_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.sw_init = 1'b1;
          state_d = ST_SW_RD;
        end
      end
      ST_IDLE: begin
        if (sts_i.cfg_hit || pend_q) begin
          cmd_o.sw_init = 1'b1;
          state_d = ST_SW_RD;
        end else begin
          cmd_o.in_stall = 1'b0;
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            case (sts_i.in_kind)
              KIND_REPORT, KIND_DELETE: state_d = ST_ROOT;
              default: state_d = sts_i.pos_ok ? ST_LEAF_RD : ST_IDLE;
            endcase
          end
        end
      end
      ST_ROOT: begin
        cmd_o.rd_root = 1'b1;
        state_d = (sts_i.item_kind == KIND_REPORT) ? ST_REPORT : ST_DEL;
      end
      ST_REPORT: begin
        cmd_o.rd_root = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DEL: begin
        cmd_o.rd_root = 1'b1;
        if (sts_i.root_live) begin
          cmd_o.del_wr = 1'b1;
          state_d = ST_UP_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_LEAF_RD: begin
        cmd_o.leaf_rd = 1'b1;
        state_d = ST_LEAF_WR;
      end
      ST_LEAF_WR: begin
        cmd_o.leaf_wr = 1'b1;
        state_d = ST_UP_RD;
      end
      ST_UP_RD: state_d = ST_UP_WR;
      ST_UP_WR: begin
        cmd_o.node_wr = 1'b1;
        state_d = sts_i.p_is_root ? ST_IDLE : ST_UP_RD;
      end
      ST_SW_RD: begin
        if (sts_i.cfg_hit) begin
          cmd_o.sw_init = 1'b1;
        end else begin
          state_d = ST_SW_WR;
        end
      end
      ST_SW_WR: begin
        if (sts_i.cfg_hit) begin
          cmd_o.sw_init = 1'b1;
          state_d = ST_SW_RD;
        end else begin
          cmd_o.node_wr   = 1'b1;
          cmd_o.step_down = 1'b1;
          state_d = sts_i.p_is_root ? ST_IDLE : ST_SW_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // a register write during an update forces a rebuild once the walk ends
    if (sts_i.cfg_hit && state_q != ST_IDLE) begin
      pend_d = 1'b1;
    end
    if (cmd_o.sw_init) begin
      pend_d = 1'b0;
    end
  end

  `TAST_ASSERT_IMP(a_load_free, cmd_o.out_load, sts_i.out_free, "result loaded over a held item")
  `TAST_ASSERT_NXT(a_accept_root,
    cmd_o.accept && (sts_i.in_kind == KIND_REPORT || sts_i.in_kind == KIND_DELETE),
    state_q == ST_ROOT, "report or delete did not read the root")
  `TAST_ASSERT_IMP(a_walk_end, state_q == ST_UP_WR && sts_i.p_is_root, state_d == ST_IDLE,
    "update walk ran past the root")
  `TAST_ASSERT_IMP(a_pend_stall, pend_q, cmd_o.in_stall, "item taken with a rebuild pending")

endmodule

`default_nettype wire

FILE: hdl/tast_dpath.sv
`default_nettype none

module tast_dpath #(
  parameter int unsigned MAX_ENTRIES = tast_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned SCORE_BITS  = tast_pkg::SCORE_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  tast_pkg::cmd_t              cmd_i,
  output tast_pkg::sts_t              sts_o,
  input  wire [1:0]                   in_kind_i,
  input  wire [tast_pkg::IDX_W-1:0]   in_entry_index_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [tast_pkg::IDX_W-1:0]  out_winner_index_o,
  output logic                        out_table_empty_o,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [tast_pkg::ADDR_W-1:0]  paddr,
  input  wire [tast_pkg::CFG_W-1:0]   pwdata,
  output logic [tast_pkg::CFG_W-1:0]  prdata,
  output logic                        pready
);
  import tast_pkg::*;

  localparam int unsigned LW  = $clog2(MAX_ENTRIES);
  localparam int unsigned NW  = LW + 1;
  localparam int unsigned M2  = 1 << LW;
  localparam int unsigned LDW = SCORE_BITS + 1;
  localparam int unsigned NDW = 1 + SCORE_BITS + NW;
  localparam logic [NW-1:0] M2V   = NW'(M2);
  localparam logic [NW-1:0] MAXV  = NW'(MAX_ENTRIES);

  logic [IDX_W-1:0]      n_raw_q;
  logic [NW-1:0]         n_eff;
  kind_e                 kind_q;
  logic [IDX_W-1:0]      pos_q;
  logic [LW-1:0]         p_q, cnt_q;
  logic                  cfg_hit;

  logic                  leaf_we, tree_we;
  logic [LW-1:0]         leaf_waddr, leaf_ra, leaf_rb, tree_ra, lo_l, lo_r;
  logic [LDW-1:0]        leaf_wdata, lra, lrb;
  logic [NDW-1:0]        tra, trb, node_new;

  logic                  l_live, r_live, take_left;
  logic [SCORE_BITS-1:0] l_score, r_score, sat_score;
  logic [NW-1:0]         l_idx, r_idx, lidx_l, lidx_r;
  logic [SCORE_BITS:0]   sum;
  logic [LW-1:0]         pos_addr, root_addr;
  logic                  out_valid_q, empty_q;
  logic [IDX_W-1:0]      winner_q;

  assign pready  = 1'b1;
  assign cfg_hit = psel && penable && pwrite && (paddr == REG_ENTRIES_IN_USE);
  assign prdata  = (paddr == REG_ENTRIES_IN_USE) ? CFG_W'(n_raw_q) : '0;

  always_comb begin
    if (n_raw_q == '0) begin
      n_eff = NW'(1);
    end else if (32'(n_raw_q) > 32'(MAX_ENTRIES)) begin
      n_eff = MAXV;
    end else begin
      n_eff = NW'(n_raw_q);
    end
  end

  // children of node p sit at 2p and 2p+1, leaves once p is in the last level
  assign lo_l      = LW'({p_q, 1'b0});
  assign lo_r      = LW'({p_q, 1'b1});
  assign lidx_l    = NW'(lo_l) + NW'(1);
  assign lidx_r    = NW'(lo_r) + NW'(1);
  assign pos_addr  = LW'(pos_q - IDX_W'(1));
  assign root_addr = LW'(tra[NW-1:0] - NW'(1));

  assign leaf_ra = cmd_i.leaf_rd ? pos_addr : lo_l;
  assign leaf_rb = lo_r;
  assign tree_ra = cmd_i.rd_root ? LW'(1) : lo_l;

  always_comb begin
    if (p_q[LW-1]) begin
      l_live  = !lra[SCORE_BITS] && (lidx_l <= n_eff);
      l_score = lra[SCORE_BITS-1:0];
      l_idx   = lidx_l;
      r_live  = !lrb[SCORE_BITS] && (lidx_r <= n_eff);
      r_score = lrb[SCORE_BITS-1:0];
      r_idx   = lidx_r;
    end else begin
      l_live  = tra[NDW-1];
      l_score = tra[NDW-2:NW];
      l_idx   = tra[NW-1:0];
      r_live  = trb[NDW-1];
      r_score = trb[NDW-2:NW];
      r_idx   = trb[NW-1:0];
    end
    // ties go to the right child
    take_left = l_live && (!r_live || (l_score > r_score));
    node_new  = take_left ? {1'b1, l_score, l_idx} : {r_live, r_score, r_idx};
  end

  always_comb begin
    sum = {1'b0, lra[SCORE_BITS-1:0]} +
          ((kind_q == KIND_ADD_THREE) ? (SCORE_BITS+1)'(3) : (SCORE_BITS+1)'(1));
    sat_score = sum[SCORE_BITS] ? '1 : sum[SCORE_BITS-1:0];
  end

  always_comb begin
    leaf_we    = cmd_i.clr_wr || cmd_i.leaf_wr || cmd_i.del_wr;
    leaf_waddr = cnt_q;
    leaf_wdata = '0;
    if (cmd_i.leaf_wr) begin
      leaf_waddr = pos_addr;
      leaf_wdata = {lra[SCORE_BITS], sat_score};
    end else if (cmd_i.del_wr) begin
      leaf_waddr = root_addr;
      leaf_wdata = {1'b1, tra[NDW-2:NW]};
    end
    tree_we = cmd_i.node_wr;
  end

  tast_ram #(.WIDTH(LDW), .DEPTH(M2)) u_leaf_ram (
    .clk_i     (clk_i),
    .we_i      (leaf_we),
    .waddr_i   (leaf_waddr),
    .wdata_i   (leaf_wdata),
    .raddr_a_i (leaf_ra),
    .raddr_b_i (leaf_rb),
    .rdata_a_o (lra),
    .rdata_b_o (lrb)
  );

  tast_ram #(.WIDTH(NDW), .DEPTH(M2)) u_tree_ram (
    .clk_i     (clk_i),
    .we_i      (tree_we),
    .waddr_i   (p_q),
    .wdata_i   (node_new),
    .raddr_a_i (tree_ra),
    .raddr_b_i (lo_r),
    .rdata_a_o (tra),
    .rdata_b_o (trb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_raw_q     <= IDX_W'(MAX_ENTRIES_DEF);
      cnt_q       <= '0;
      p_q         <= '1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_hit) begin
        n_raw_q <= pwdata[IDX_W-1:0];
      end
      if (cmd_i.clr_wr) begin
        cnt_q <= cnt_q + LW'(1);
      end
      if (cmd_i.sw_init) begin
        p_q <= '1;
      end else if (cmd_i.leaf_wr) begin
        p_q <= LW'((NW'(pos_addr) + M2V) >> 1);
      end else if (cmd_i.del_wr) begin
        p_q <= LW'((NW'(root_addr) + M2V) >> 1);
      end else if (cmd_i.node_wr) begin
        p_q <= cmd_i.step_down ? (p_q - LW'(1)) : (p_q >> 1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_e'(in_kind_i);
      pos_q  <= in_entry_index_i;
    end
    if (cmd_i.out_load) begin
      winner_q <= tra[NDW-1] ? IDX_W'(tra[NW-1:0]) : '0;
      empty_q  <= !tra[NDW-1];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_winner_index_o = winner_q;
  assign out_table_empty_o  = empty_q;

  assign sts_o.cfg_hit   = cfg_hit;
  assign sts_o.clr_last  = (cnt_q == '1);
  assign sts_o.in_kind   = kind_e'(in_kind_i);
  assign sts_o.item_kind = kind_q;
  assign sts_o.pos_ok    = (in_entry_index_i != '0) &&
                           (32'(in_entry_index_i) <= 32'(n_eff));
  assign sts_o.root_live = tra[NDW-1];
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign sts_o.p_is_root = (p_q == LW'(1));

endmodule

`default_nettype wire

FILE: hdl/tournament_argmax_score_table_core.sv
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o  in_kind_i, in_entry_index_i
// out      output     out_valid_o/out_stall_i out_winner_index_o, out_table_empty_o
// cfg      input      apb psel/penable       reg 0 entries_in_use at byte 0
//
// report and delete read the root; delete and add then walk up the tree,
// with one child-pair read and one node write per level.
// after reset a clearing pass over every leaf and a tree build run before the
// first item is taken.
// a write to entries_in_use starts the same build again.
// a held result does not block new items; only a report waits for the output register.
`default_nettype none

module tournament_argmax_score_table_core #(
  parameter int unsigned MAX_ENTRIES = tast_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned SCORE_BITS  = tast_pkg::SCORE_BITS_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_stall_o,
  input  wire [1:0]                   in_kind_i,
  input  wire [tast_pkg::IDX_W-1:0]   in_entry_index_i,
  output logic                        out_valid_o,
  input  wire                         out_stall_i,
  output logic [tast_pkg::IDX_W-1:0]  out_winner_index_o,
  output logic                        out_table_empty_o,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire [tast_pkg::ADDR_W-1:0]  paddr,
  input  wire [tast_pkg::CFG_W-1:0]   pwdata,
  output logic [tast_pkg::CFG_W-1:0]  prdata,
  output logic                        pready
);
  import tast_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tast_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tast_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .SCORE_BITS  (SCORE_BITS)
  ) u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .in_kind_i          (in_kind_i),
    .in_entry_index_i   (in_entry_index_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_winner_index_o (out_winner_index_o),
    .out_table_empty_o  (out_table_empty_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  assign in_stall_o = cmd.in_stall;

endmodule

`default_nettype wire
